// ===== hdl/rlcas_pkg.sv =====
package rlcas_pkg;

    localparam int MAX_ORDERS = 1024;

    localparam int H_W     = 10;
    localparam int R_W     = 32;
    localparam int L_W     = 32;
    localparam int C_W     = 40;
    localparam int FREQ_W  = 24;
    localparam int F_W     = 35;
    localparam int OMEGA_W = 38;
    localparam int XL_W    = 54;
    localparam int MAG_W   = 57;
    localparam int G_W     = 39;
    localparam int B_W     = 40;
    localparam int CFG_W   = 40;
    localparam int IDX_W   = 3;

    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

    localparam int MUL_W      = 64;
    localparam int DIV_NUM_W  = 128;
    localparam int DIV_DEN_W  = 120;
    localparam int DIV_QUO_W  = 72;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = DIV_QUO_W / DIV_BITS;

    localparam logic [IDX_W-1:0] CFG_RESISTANCE  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_INDUCTANCE  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CAPACITANCE = 3'd2;
    localparam logic [IDX_W-1:0] CFG_START_FREQ  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_FREQ_STEP   = 3'd4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ZERO_OMEGA = 2'd1;
    localparam logic [1:0] ST_ZERO_IMP   = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [OMEGA_W-1:0] omega;
        logic               cap_nz;
        logic [XL_W-1:0]    xl;
        logic [MAG_W-1:0]   mag;
        logic               neg;
        logic [1:0]         status;
    } side_t;

endpackage

// ===== hdl/series_rlc_admittance_sweep_core.sv =====
// channel  | handshake            | payload
// input    | in_valid / in_stall  | harmonic_index
// output   | out_valid / out_stall| conductance, susceptance, status
// config   | cfg_we               | cfg_index, cfg_data
//
// one index per cycle sustained while no result waits under out_stall, 49 register stages
// stage count set by three 3-stage multipliers and two radix-16 dividers in series
// whole pipeline advances together; it holds while a result waits under out_stall
// reset clears configuration to zero and all valid bits
module series_rlc_admittance_sweep_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rlcas_pkg::H_W-1:0]           harmonic_index,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rlcas_pkg::G_W-1:0]           conductance,
    output logic signed [rlcas_pkg::B_W-1:0]    susceptance,
    output logic [1:0]                          status,
    input  logic                                cfg_we,
    input  logic [rlcas_pkg::IDX_W-1:0]         cfg_index,
    input  logic [rlcas_pkg::CFG_W-1:0]         cfg_data
);
    import rlcas_pkg::*;

    localparam logic [G_W-1:0] G_MAX = {G_W{1'b1}};
    localparam logic [B_W-1:0] B_NEG = {1'b1, {(B_W-1){1'b0}}};

    logic [R_W-1:0]     resistance_reg;
    logic [L_W-1:0]     inductance_reg;
    logic [C_W-1:0]     capacitance_reg;
    logic [FREQ_W-1:0]  start_reg;
    logic [FREQ_W-1:0]  step_reg;

    logic               en;
    logic [H_W-1:0]     h_clamp;
    logic [F_W-1:0]     f_reg;
    logic [F_W-1:0]     f_next;
    side_t              s0_side_reg;

    logic [127:0]       p1;
    logic [127:0]       p1_round;
    logic [127:0]       p2;
    logic [127:0]       p2_round;
    logic [127:0]       p3;
    logic [127:0]       p4;
    logic [127:0]       p5;
    side_t              m1_side;
    side_t              side1;
    side_t              m2_side;
    side_t              m3_side;
    side_t              side2;
    logic [DIV_NUM_W-1:0] n1;
    logic [DIV_DEN_W-1:0] d1;
    logic [DIV_QUO_W-1:0] q1;
    side_t              d1_side;
    side_t              side3;
    logic [MAG_W-1:0]   xc;
    logic [MAG_W-1:0]   xl_ext;
    side_t              m4_side;
    side_t              m5_side;
    side_t              side4;
    logic [115:0]       dsum;
    logic [DIV_NUM_W-1:0] ng;
    logic [DIV_NUM_W-1:0] nb;
    logic [DIV_DEN_W-1:0] dd;
    logic [DIV_QUO_W-1:0] qg;
    logic [DIV_QUO_W-1:0] qb;
    side_t              d2_side;
    side_t              d3_side;

    logic [G_W-1:0]     g_next;
    logic [B_W-1:0]     b_next;
    logic [B_W-1:0]     bmag;
    logic               out_valid_reg;
    logic [G_W-1:0]     g_reg;
    logic [B_W-1:0]     b_reg;
    logic [1:0]         status_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resistance_reg  <= '0;
            inductance_reg  <= '0;
            capacitance_reg <= '0;
            start_reg       <= '0;
            step_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RESISTANCE:  resistance_reg  <= cfg_data[R_W-1:0];
                CFG_INDUCTANCE:  inductance_reg  <= cfg_data[L_W-1:0];
                CFG_CAPACITANCE: capacitance_reg <= cfg_data[C_W-1:0];
                CFG_START_FREQ:  start_reg       <= cfg_data[FREQ_W-1:0];
                CFG_FREQ_STEP:   step_reg        <= cfg_data[FREQ_W-1:0];
                default:         ;
            endcase
        end
    end

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // frequency
    assign h_clamp = ({7'b0, harmonic_index} >= 17'(MAX_ORDERS))
                   ? H_W'(MAX_ORDERS - 1) : harmonic_index;
    assign f_next  = F_W'(start_reg) + F_W'(h_clamp) * F_W'(step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_side_reg <= '0;
        end
        else if (en)
        begin
            s0_side_reg <= '{valid: in_valid, default: '0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg <= f_next;
        end
    end

    // omega
    rlcas_mul u_mul_omega (
        .clk(clk), .rst_n(rst_n), .en(en),
        .a(MUL_W'(f_reg)), .b(MUL_W'(TWO_PI_Q29)),
        .side_in(s0_side_reg), .p(p1), .side_out(m1_side)
    );

    assign p1_round = p1 + (128'd1 << 28);
    always_comb
    begin
        side1       = m1_side;
        side1.omega = p1_round[OMEGA_W+28:29];
    end

    // inductive reactance and omega*C
    rlcas_mul u_mul_xl (
        .clk(clk), .rst_n(rst_n), .en(en),
        .a(MUL_W'(side1.omega)), .b(MUL_W'(inductance_reg)),
        .side_in(side1), .p(p2), .side_out(m2_side)
    );

    rlcas_mul u_mul_wc (
        .clk(clk), .rst_n(rst_n), .en(en),
        .a(MUL_W'(side1.omega)), .b(MUL_W'(capacitance_reg)),
        .side_in(side1), .p(p3), .side_out(m3_side)
    );

    assign p2_round = p2 + (128'd1 << 15);
    always_comb
    begin
        side2        = m3_side;
        side2.valid  = m2_side.valid;
        side2.xl     = p2_round[XL_W+15:16];
        side2.cap_nz = (capacitance_reg != '0);
        side2.status = (side2.cap_nz && (m3_side.omega == '0)) ? ST_ZERO_OMEGA : ST_OK;
    end

    // capacitive reactance, round(2^64 / (omega*C))
    assign n1 = (128'd1 << 65) + p3;
    assign d1 = DIV_DEN_W'({p3[78:0], 1'b0});

    rlcas_div u_div_xc (
        .clk(clk), .rst_n(rst_n), .en(en),
        .num(n1), .den(d1), .side_in(side2),
        .quo(q1), .side_out(d1_side)
    );

    assign xl_ext = MAG_W'(d1_side.xl);
    always_comb
    begin
        if (!d1_side.cap_nz)
        begin
            xc = '0;
        end
        else if (q1 > (72'd1 << 56))
        begin
            xc = {1'b1, {(MAG_W-1){1'b0}}};
        end
        else
        begin
            xc = q1[MAG_W-1:0];
        end
        side3     = d1_side;
        side3.neg = xl_ext < xc;
        side3.mag = side3.neg ? xc - xl_ext : xl_ext - xc;
        if ((d1_side.status == ST_OK) && (resistance_reg == '0) && (side3.mag == '0))
        begin
            side3.status = ST_ZERO_IMP;
        end
    end

    // denominator
    rlcas_mul u_mul_mag (
        .clk(clk), .rst_n(rst_n), .en(en),
        .a(MUL_W'(side3.mag)), .b(MUL_W'(side3.mag)),
        .side_in(side3), .p(p4), .side_out(m4_side)
    );

    rlcas_mul u_mul_res (
        .clk(clk), .rst_n(rst_n), .en(en),
        .a(MUL_W'(resistance_reg)), .b(MUL_W'(resistance_reg)),
        .side_in(side3), .p(p5), .side_out(m5_side)
    );

    always_comb
    begin
        side4       = m4_side;
        side4.valid = m5_side.valid;
    end

    assign dsum = {2'b0, p4[113:0]} + {52'b0, p5[63:0]};
    assign ng   = (DIV_NUM_W'(resistance_reg) << 41) + DIV_NUM_W'(dsum);
    assign nb   = (DIV_NUM_W'(m4_side.mag) << 41) + DIV_NUM_W'(dsum);
    assign dd   = DIV_DEN_W'({dsum, 1'b0});

    rlcas_div u_div_g (
        .clk(clk), .rst_n(rst_n), .en(en),
        .num(ng), .den(dd), .side_in(side4),
        .quo(qg), .side_out(d2_side)
    );

    rlcas_div u_div_b (
        .clk(clk), .rst_n(rst_n), .en(en),
        .num(nb), .den(dd), .side_in(side4),
        .quo(qb), .side_out(d3_side)
    );

    // saturation and result
    always_comb
    begin
        g_next = (qg > DIV_QUO_W'(G_MAX)) ? G_MAX : qg[G_W-1:0];
        if (d3_side.neg)
        begin
            bmag   = '0;
            b_next = (qb > DIV_QUO_W'(G_MAX)) ? {1'b0, G_MAX} : {1'b0, qb[G_W-1:0]};
        end
        else
        begin
            bmag   = (qb > DIV_QUO_W'(B_NEG)) ? B_NEG : qb[B_W-1:0];
            b_next = B_W'(0) - bmag;
        end
        if (d2_side.status != ST_OK)
        begin
            g_next = '0;
            b_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d2_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg      <= g_next;
            b_reg      <= b_next;
            status_reg <= d2_side.status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign conductance = g_reg;
    assign susceptance = b_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> ((conductance == '0) && (susceptance == '0)))
        else $error("special case result not zero");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

    a_zero_imp_res: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_ZERO_IMP)) |-> (resistance_reg == '0))
        else $error("zero impedance with nonzero resistance");

    a_zero_omega_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_ZERO_OMEGA)) |-> (capacitance_reg != '0))
        else $error("zero omega flagged without capacitor");
`endif

endmodule

// ===== hdl/rlcas_mul.sv =====
module rlcas_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic [rlcas_pkg::MUL_W-1:0]         a,
    input  logic [rlcas_pkg::MUL_W-1:0]         b,
    input  rlcas_pkg::side_t                    side_in,
    output logic [2*rlcas_pkg::MUL_W-1:0]       p,
    output rlcas_pkg::side_t                    side_out
);
    import rlcas_pkg::*;

    logic [MUL_W-1:0]   a_reg;
    logic [MUL_W-1:0]   b_reg;
    logic [63:0]        ll_reg;
    logic [63:0]        lh_reg;
    logic [63:0]        hl_reg;
    logic [63:0]        hh_reg;
    logic [2*MUL_W-1:0] p_reg;
    logic [2*MUL_W-1:0] p_next;
    side_t              side_a_reg;
    side_t              side_b_reg;
    side_t              side_c_reg;

    assign p_next = {hh_reg, 64'b0}
                  + ({64'b0, lh_reg} << 32)
                  + ({64'b0, hl_reg} << 32)
                  + {64'b0, ll_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a_reg <= '0;
            side_b_reg <= '0;
            side_c_reg <= '0;
        end
        else if (en)
        begin
            side_a_reg <= side_in;
            side_b_reg <= side_a_reg;
            side_c_reg <= side_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg  <= a;
            b_reg  <= b;
            ll_reg <= a_reg[31:0] * b_reg[31:0];
            lh_reg <= a_reg[31:0] * b_reg[63:32];
            hl_reg <= a_reg[63:32] * b_reg[31:0];
            hh_reg <= a_reg[63:32] * b_reg[63:32];
            p_reg  <= p_next;
        end
    end

    assign p        = p_reg;
    assign side_out = side_c_reg;

endmodule

// ===== hdl/rlcas_div.sv =====
module rlcas_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [rlcas_pkg::DIV_NUM_W-1:0]   num,
    input  logic [rlcas_pkg::DIV_DEN_W-1:0]   den,
    input  rlcas_pkg::side_t                  side_in,
    output logic [rlcas_pkg::DIV_QUO_W-1:0]   quo,
    output rlcas_pkg::side_t                  side_out
);
    import rlcas_pkg::*;

    logic [DIV_DEN_W-1:0] rem_reg  [0:DIV_STAGES];
    logic [DIV_QUO_W-1:0] low_reg  [0:DIV_STAGES];
    logic [DIV_DEN_W-1:0] den_reg  [0:DIV_STAGES];
    logic [DIV_QUO_W-1:0] quo_reg  [0:DIV_STAGES];
    side_t                side_reg [0:DIV_STAGES];

    logic [DIV_DEN_W-1:0] rem_next [0:DIV_STAGES-1];
    logic [DIV_QUO_W-1:0] low_next [0:DIV_STAGES-1];
    logic [DIV_QUO_W-1:0] quo_next [0:DIV_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg[0] <= '0;
        end
        else if (en)
        begin
            side_reg[0] <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_QUO_W]);
            low_reg[0] <= num[DIV_QUO_W-1:0];
            den_reg[0] <= den;
            quo_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        always_comb
        begin
            logic [DIV_DEN_W:0]   t;
            logic [DIV_DEN_W-1:0] r;
            logic [DIV_QUO_W-1:0] l;
            logic [DIV_QUO_W-1:0] q;
            r = rem_reg[k];
            l = low_reg[k];
            q = quo_reg[k];
            for (int j = 0; j < DIV_BITS; j++)
            begin
                t = {r, l[DIV_QUO_W-1]};
                l = {l[DIV_QUO_W-2:0], 1'b0};
                if (t >= {1'b0, den_reg[k]})
                begin
                    t = t - {1'b0, den_reg[k]};
                    q = {q[DIV_QUO_W-2:0], 1'b1};
                end
                else
                begin
                    q = {q[DIV_QUO_W-2:0], 1'b0};
                end
                r = t[DIV_DEN_W-1:0];
            end
            rem_next[k] = r;
            low_next[k] = l;
            quo_next[k] = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[k+1] <= '0;
            end
            else if (en)
            begin
                side_reg[k+1] <= side_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next[k];
                low_reg[k+1] <= low_next[k];
                den_reg[k+1] <= den_reg[k];
                quo_reg[k+1] <= quo_next[k];
            end
        end
    end

    assign quo      = quo_reg[DIV_STAGES];
    assign side_out = side_reg[DIV_STAGES];

endmodule

// ===== sim/tb_series_rlc_admittance_sweep_core.sv =====
`timescale 1ns / 1ps

module tb_series_rlc_admittance_sweep_core;
    import rlcas_pkg::*;

    localparam logic [IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [G_W-1:0] conductance;
        logic [B_W-1:0] susceptance;
        logic [1:0]     status;
    } admittance_t;

    class admittance_scoreboard;
        bit [127:0] r_ohm;
        bit [127:0] l_henry;
        bit [127:0] c_farad;
        bit [127:0] f_start;
        bit [127:0] f_step;
        admittance_t expected_q[$];
        int errors;

        function new();
            r_ohm = 0;
            l_henry = 0;
            c_farad = 0;
            f_start = 0;
            f_step = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_RESISTANCE:  r_ohm = data[R_W-1:0];
                CFG_INDUCTANCE:  l_henry = data[L_W-1:0];
                CFG_CAPACITANCE: c_farad = data[C_W-1:0];
                CFG_START_FREQ:  f_start = data[FREQ_W-1:0];
                CFG_FREQ_STEP:   f_step = data[FREQ_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [127:0] div_round(bit [127:0] n, bit [127:0] d);
            return ((n << 1) + d) / (d << 1);
        endfunction

        function bit [127:0] clip(bit [127:0] v, bit [127:0] lim);
            return (v > lim) ? lim : v;
        endfunction

        function void note_input(logic [H_W-1:0] h);
            bit [127:0] hh, f, omega, xl, xc, mag, d, g, bmag;
            bit neg;
            admittance_t e;
            hh = h;
            if (hh >= MAX_ORDERS)
                hh = MAX_ORDERS - 1;
            e = '0;
            f = f_start + hh * f_step;
            omega = (f * 128'(TWO_PI_Q29) + (128'd1 << 28)) >> 29;
            xl = (omega * l_henry + (128'd1 << 15)) >> 16;
            xc = 0;
            if (c_farad != 0) begin
                if (omega == 0) begin
                    e.status = ST_ZERO_OMEGA;
                    expected_q.push_back(e);
                    return;
                end
                xc = clip(div_round(128'd1 << 64, omega * c_farad), 128'd1 << 56);
            end
            neg = xl < xc;
            mag = neg ? xc - xl : xl - xc;
            d = r_ohm * r_ohm + mag * mag;
            if (d == 0) begin
                e.status = ST_ZERO_IMP;
                expected_q.push_back(e);
                return;
            end
            g = clip(div_round(r_ohm << 40, d), (128'd1 << 39) - 1);
            e.conductance = g[G_W-1:0];
            if (neg) begin
                bmag = clip(div_round(mag << 40, d), (128'd1 << 39) - 1);
                e.susceptance = bmag[B_W-1:0];
            end
            else begin
                bmag = clip(div_round(mag << 40, d), 128'd1 << 39);
                e.susceptance = -bmag[B_W-1:0];
            end
            e.status = ST_OK;
            expected_q.push_back(e);
        endfunction

        function void check_result(logic [G_W-1:0] g, logic [B_W-1:0] b, logic [1:0] s);
            admittance_t e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result g=%h b=%h s=%0d", g, b, s);
                return;
            end
            e = expected_q.pop_front();
            if (e.conductance !== g || e.susceptance !== b || e.status !== s) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp g=%h b=%h s=%0d, got g=%h b=%h s=%0d",
                        e.conductance, e.susceptance, e.status, g, b, s);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [H_W-1:0] harmonic_index;
    logic out_valid;
    logic out_stall;
    logic [G_W-1:0] conductance;
    logic signed [B_W-1:0] susceptance;
    logic [1:0] status;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    admittance_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    series_rlc_admittance_sweep_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .harmonic_index(harmonic_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .conductance(conductance),
        .susceptance(susceptance),
        .status(status),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(harmonic_index);
            if (out_valid && !out_stall)
                sb.check_result(conductance, susceptance, status);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_index(input logic [H_W-1:0] h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        harmonic_index <= h;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.set_reg(idx, data);
    endtask

    task automatic load_branch(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] l,
                               input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] f0,
                               input logic [CFG_W-1:0] fs);
        write_reg(CFG_RESISTANCE, r);
        write_reg(CFG_INDUCTANCE, l);
        write_reg(CFG_CAPACITANCE, c);
        write_reg(CFG_START_FREQ, f0);
        write_reg(CFG_FREQ_STEP, fs);
        write_reg(CFG_UNUSED_LO, CFG_W'({$urandom, $urandom}));
        write_reg(CFG_UNUSED_HI, CFG_W'({$urandom, $urandom}));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_value(int width, int typical);
        int sel;
        logic [CFG_W-1:0] full;
        sel = $urandom_range(9);
        full = CFG_W'({$urandom, $urandom});
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return (CFG_W'(1) << width) - 1;
        else if (sel <= 3)
            return full & ((CFG_W'(1) << width) - 1);
        else
            return CFG_W'($urandom_range(typical));
    endfunction

    task automatic load_random_branch();
        load_branch(pick_value(R_W, 1 << 22), pick_value(L_W, 1 << 18),
                    pick_value(C_W, 1 << 24), pick_value(FREQ_W, 1 << 16),
                    pick_value(FREQ_W, 1 << 14));
    endtask

    task automatic run_phase(input int count, input int idle_pct, input int stl_pct,
                             input bit hold, input bit pause);
        send_idle_pct = idle_pct;
        stall_pct = stl_pct;
        if (hold)
            hold_left = 300;
        for (int i = 0; i < count; i++)
        begin
            if (pause && i == count / 2)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            send_index(H_W'($urandom_range(MAX_ORDERS - 1)));
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        harmonic_index = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero impedance straight out of reset
        send_index('0);
        send_index(H_W'(MAX_ORDERS - 1));
        wait_drained();

        // capacitor with zero omega at index zero
        load_branch(CFG_W'(1 << 20), CFG_W'(1 << 16), CFG_W'(1 << 20), '0, CFG_W'(12800));
        send_index('0);
        send_index(H_W'(1));
        send_index(H_W'(MAX_ORDERS - 1));
        send_index(H_W'(512));
        wait_drained();

        // all registers at full scale
        load_branch('1, '1, '1, '1, '1);
        send_index('0);
        send_index(H_W'(MAX_ORDERS - 1));
        send_index(H_W'(341));
        wait_drained();

        // pure resistor, pure inductor, resonance neighborhood
        load_branch(CFG_W'(1), '0, '0, CFG_W'(1), CFG_W'(1));
        send_index('0);
        send_index(H_W'(MAX_ORDERS - 1));
        wait_drained();
        load_branch('0, CFG_W'(1 << 24), '0, CFG_W'(256), CFG_W'(256));
        send_index('0);
        send_index(H_W'(10));
        wait_drained();
        load_branch(CFG_W'(1 << 16), CFG_W'(16777), CFG_W'(1099512), CFG_W'(256),
                    CFG_W'(256 * 16));
        for (int h = 0; h < 12; h++)
            send_index(H_W'(h));
        wait_drained();

        load_random_branch();
        run_phase(100, 0, 0, 0, 0);
        load_random_branch();
        run_phase(100, 65, 0, 0, 0);
        load_random_branch();
        run_phase(100, 0, 65, 0, 0);
        load_random_branch();
        run_phase(100, 15, 15, 0, 0);
        load_random_branch();
        run_phase(100, 0, 0, 1, 0);
        load_random_branch();
        run_phase(100, 15, 15, 0, 1);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
